FILE: sv/scalc_pkg.sv
// Shared types and codes for the stack calculator.
package scalc_pkg;

    localparam int DEFAULT_STACK_DEPTH = 64;
    localparam int DATA_W = 32;

    localparam logic [2:0] FUNC_PUSH = 3'd0;
    localparam logic [2:0] FUNC_POP = 3'd1;
    localparam logic [2:0] FUNC_RD_TOP = 3'd2;
    localparam logic [2:0] FUNC_RD_BOT = 3'd3;
    localparam logic [2:0] FUNC_ADD = 3'd4;
    localparam logic [2:0] FUNC_SUB = 3'd5;
    localparam logic [2:0] FUNC_MUL = 3'd6;
    localparam logic [2:0] FUNC_DIV = 3'd7;

    localparam logic [2:0] ST_OK = 3'd0;
    localparam logic [2:0] ST_EMPTY = 3'd1;
    localparam logic [2:0] ST_RANGE = 3'd2;
    localparam logic [2:0] ST_FEW = 3'd3;
    localparam logic [2:0] ST_DIV0 = 3'd4;
    localparam logic [2:0] ST_FULL = 3'd5;

    typedef struct packed {
        logic [2:0] func;
        logic signed [31:0] push_value;
        logic [5:0] index;
    } in_beat_t;

    typedef struct packed {
        logic signed [31:0] value;
        logic [2:0] status;
        logic [6:0] depth;
    } out_beat_t;

    // Datapath commands from the controller
    typedef struct packed {
        logic load_a;
        logic load_b;
        logic load_res;
        logic div_start;
    } dp_cmd_t;

    typedef struct packed {
        logic div_done;
        logic a_zero;
    } dp_stat_t;

endpackage

FILE: sv/stack_calculator_engine_unit.sv
// Top level of the integer stack calculator.
// One operation per beat, one result beat per operation. Push and most error
// results are fastest, then pop and reads, then a divide by zero, then
// add/subtract/multiply, and a divide is slowest: the 32-step shift-subtract
// divider sets the worst case.
// A new beat is taken once the previous result has been delivered. The stack
// lives in a RAM of STACK_DEPTH words with registered read; no clearing pass.
module stack_calculator_engine_unit #(
    parameter int STACK_DEPTH = scalc_pkg::DEFAULT_STACK_DEPTH
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  scalc_pkg::in_beat_t  in_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output scalc_pkg::out_beat_t out_data
);
    import scalc_pkg::*;

    localparam int AW = $clog2(STACK_DEPTH);

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [31:0]   mem_wdata;
    logic [AW-1:0] mem_raddr;
    logic [31:0]   mem_rdata;
    logic [2:0]    func;
    dp_cmd_t       cmd;
    dp_stat_t      stat;
    logic [31:0]   result;

    scalc_ram #(.WIDTH(DATA_W), .DEPTH(STACK_DEPTH)) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    scalc_ctrl #(.STACK_DEPTH(STACK_DEPTH)) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata),
        .func      (func),
        .cmd       (cmd),
        .stat      (stat),
        .result    (result)
    );

    scalc_datapath u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .func   (func),
        .rdata  (mem_rdata),
        .cmd    (cmd),
        .stat   (stat),
        .result (result)
    );

`ifndef SYNTH
    a_depth_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (STACK_DEPTH >= 128 || out_data.depth <= 7'(STACK_DEPTH)))
        else $error("depth beyond stack size");
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status != ST_OK |-> out_data.value == '0)
        else $error("error beat with nonzero value");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("input taken while result pending");
`endif

endmodule

FILE: sv/scalc_ram.sv
// Generic single-port-write, one-read-port RAM with registered read data.
module scalc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: sv/scalc_datapath.sv
// Operand registers, ALU, multiplier and iterative floor divider.
module scalc_datapath (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic [2:0]               func,
    input  logic [31:0]              rdata,
    input  scalc_pkg::dp_cmd_t       cmd,
    output scalc_pkg::dp_stat_t      stat,
    output logic [31:0]              result
);
    import scalc_pkg::*;

    logic [31:0] a_reg;
    logic [31:0] b_reg;
    logic [31:0] res_reg;
    logic [31:0] res_next;
    logic [31:0] prod;

    // Divider state
    logic        busy_reg;
    logic        busy_next;
    logic [5:0]  cnt_reg;
    logic [5:0]  cnt_next;
    logic [31:0] quo_reg;
    logic [31:0] quo_next;
    logic [32:0] rem_reg;
    logic [32:0] rem_next;
    logic [31:0] dvs_reg;
    logic        done_reg;
    logic        done_next;
    logic [31:0] mag_a;
    logic [31:0] mag_b;
    logic [32:0] trial;
    logic        neg_q;
    logic [31:0] fq;

    assign mag_a = a_reg[31] ? (~a_reg + 32'd1) : a_reg;
    assign mag_b = b_reg[31] ? (~b_reg + 32'd1) : b_reg;
    assign neg_q = a_reg[31] ^ b_reg[31];
    assign trial = {rem_reg[31:0], quo_reg[31]} - {1'b0, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next = cnt_reg;
        quo_next = quo_reg;
        rem_next = rem_reg;
        done_next = 1'b0;
        if (cmd.div_start)
        begin
            busy_next = 1'b1;
            cnt_next = 6'd0;
            quo_next = mag_b;
            rem_next = 33'd0;
        end
        else if (busy_reg)
        begin
            if (!trial[32])
            begin
                rem_next = trial;
                quo_next = {quo_reg[30:0], 1'b1};
            end
            else
            begin
                rem_next = {rem_reg[31:0], quo_reg[31]};
                quo_next = {quo_reg[30:0], 1'b0};
            end
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd31)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_comb
    begin
        if (neg_q)
        begin
            fq = ~quo_reg + 32'd1 - ((rem_reg[31:0] != 32'd0) ? 32'd1 : 32'd0);
        end
        else
        begin
            fq = quo_reg;
        end
    end

    assign prod = a_reg * b_reg;

    always_comb
    begin
        case (func)
            FUNC_ADD: res_next = a_reg + b_reg;
            FUNC_SUB: res_next = b_reg - a_reg;
            FUNC_MUL: res_next = prod;
            FUNC_DIV: res_next = fq;
            default:  res_next = a_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= 6'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        if (cmd.div_start)
        begin
            dvs_reg <= mag_a;
        end
        if (cmd.load_a)
        begin
            a_reg <= rdata;
        end
        if (cmd.load_b)
        begin
            b_reg <= rdata;
        end
        if (cmd.load_res)
        begin
            res_reg <= res_next;
        end
    end

    assign stat.div_done = done_reg;
    assign stat.a_zero = (a_reg == 32'd0);
    assign result = res_reg;

endmodule

FILE: sv/scalc_ctrl.sv
// Controller: sequences stack memory accesses and arithmetic for each beat.
module scalc_ctrl #(
    parameter int STACK_DEPTH = scalc_pkg::DEFAULT_STACK_DEPTH
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  scalc_pkg::in_beat_t            in_data,
    output logic                           out_valid,
    input  logic                           out_stall,
    output scalc_pkg::out_beat_t           out_data,
    output logic                           mem_we,
    output logic [$clog2(STACK_DEPTH)-1:0] mem_waddr,
    output logic [31:0]                    mem_wdata,
    output logic [$clog2(STACK_DEPTH)-1:0] mem_raddr,
    input  logic [31:0]                    mem_rdata,
    output logic [2:0]                     func,
    output scalc_pkg::dp_cmd_t             cmd,
    input  scalc_pkg::dp_stat_t            stat,
    input  logic [31:0]                    result
);
    import scalc_pkg::*;

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD_A = 3'd1;
    localparam logic [2:0] S_RD_B = 3'd2;
    localparam logic [2:0] S_EXEC = 3'd3;
    localparam logic [2:0] S_DIV = 3'd4;
    localparam logic [2:0] S_WB = 3'd5;
    localparam logic [2:0] S_READ = 3'd6;

    logic [2:0]    state_reg;
    logic [2:0]    state_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    in_beat_t      item_reg;
    in_beat_t      item_next;
    logic          ovalid_reg;
    logic          ovalid_next;
    out_beat_t     odata_reg;
    out_beat_t     odata_next;
    logic          accept;
    logic [CW-1:0] idx_ext;

    assign in_stall = (state_reg != S_IDLE) || ovalid_reg;
    assign accept = in_valid && !in_stall;
    assign idx_ext = CW'(in_data.index);
    assign func = item_reg.func;

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        item_next = item_reg;
        ovalid_next = ovalid_reg && out_stall;
        odata_next = odata_reg;
        mem_we = 1'b0;
        mem_waddr = count_reg[AW-1:0];
        mem_wdata = in_data.push_value;
        mem_raddr = AW'(count_reg - CW'(1));
        cmd = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    item_next = in_data;
                    odata_next.value = '0;
                    odata_next.status = ST_OK;
                    odata_next.depth = 7'(count_reg);
                    case (in_data.func)
                        FUNC_PUSH:
                        begin
                            if (count_reg == CW'(STACK_DEPTH))
                            begin
                                odata_next.status = ST_FULL;
                            end
                            else
                            begin
                                mem_we = 1'b1;
                                count_next = count_reg + CW'(1);
                                odata_next.depth = 7'(count_reg + CW'(1));
                            end
                            ovalid_next = 1'b1;
                        end
                        FUNC_POP:
                        begin
                            if (count_reg == '0)
                            begin
                                odata_next.status = ST_EMPTY;
                                ovalid_next = 1'b1;
                            end
                            else
                            begin
                                count_next = count_reg - CW'(1);
                                odata_next.depth = 7'(count_reg - CW'(1));
                                state_next = S_READ;
                            end
                        end
                        FUNC_RD_TOP, FUNC_RD_BOT:
                        begin
                            if (idx_ext >= count_reg || in_data.index >= 6'(STACK_DEPTH)
                                && STACK_DEPTH < 64)
                            begin
                                odata_next.status = ST_RANGE;
                                ovalid_next = 1'b1;
                            end
                            else
                            begin
                                if (in_data.func == FUNC_RD_TOP)
                                begin
                                    mem_raddr = AW'(count_reg - CW'(1) - idx_ext);
                                end
                                else
                                begin
                                    mem_raddr = AW'(idx_ext);
                                end
                                state_next = S_READ;
                            end
                        end
                        default:
                        begin
                            if (count_reg < CW'(2))
                            begin
                                odata_next.status = ST_FEW;
                                ovalid_next = 1'b1;
                            end
                            else
                            begin
                                state_next = S_RD_A;
                            end
                        end
                    endcase
                end
            end
            S_READ:
            begin
                odata_next.value = mem_rdata;
                ovalid_next = 1'b1;
                state_next = S_IDLE;
            end
            S_RD_A:
            begin
                mem_raddr = AW'(count_reg - CW'(2));
                cmd.load_a = 1'b1;
                state_next = S_RD_B;
            end
            S_RD_B:
            begin
                cmd.load_b = 1'b1;
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                if (item_reg.func == FUNC_DIV)
                begin
                    if (stat.a_zero)
                    begin
                        count_next = count_reg - CW'(2);
                        odata_next.status = ST_DIV0;
                        odata_next.depth = 7'(count_reg - CW'(2));
                        ovalid_next = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cmd.div_start = 1'b1;
                        state_next = S_DIV;
                    end
                end
                else
                begin
                    cmd.load_res = 1'b1;
                    state_next = S_WB;
                end
            end
            S_DIV:
            begin
                if (stat.div_done)
                begin
                    cmd.load_res = 1'b1;
                    state_next = S_WB;
                end
            end
            S_WB:
            begin
                mem_we = 1'b1;
                mem_waddr = AW'(count_reg - CW'(2));
                mem_wdata = result;
                count_next = count_reg - CW'(1);
                odata_next.value = result;
                odata_next.depth = 7'(count_reg - CW'(1));
                ovalid_next = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        odata_reg <= odata_next;
    end

    assign out_valid = ovalid_reg;
    assign out_data = odata_reg;

endmodule

FILE: dv/tb_stack_calculator_engine_unit.sv
// Testbench for the stack calculator: directed table, fill/drain, random ops, checked.
module tb_stack_calculator_engine_unit;
    import scalc_pkg::*;

    localparam int DEPTH = DEFAULT_STACK_DEPTH;
    localparam int RANDOM_OPS = 1300;
    localparam int CYCLE_LIMIT = 600000;

    typedef struct {
        logic [2:0] func;
        logic [31:0] operand;
        logic [5:0] index;
        bit known;
        logic [31:0] value;
        logic [2:0] status;
        logic [6:0] depth;
    } stim_row_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    in_beat_t in_data;
    logic out_valid;
    logic out_stall;
    out_beat_t out_data;

    logic [31:0] calc_mem [DEPTH];
    int calc_count;
    out_beat_t result_queue [$];
    int mismatch_count;
    int cycle_count;
    bit in_quiet;
    bit out_quiet;
    int out_burst;

    stack_calculator_engine_unit dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .in_data(in_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data(out_data)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #2 clk = ~clk;
        end
    end

    function automatic logic [31:0] floor_quotient(logic [31:0] b, logic [31:0] a);
        longint nb;
        longint na;
        longint q;
        longint r;
        nb = longint'($signed(b));
        na = longint'($signed(a));
        q = nb / na;
        r = nb - q * na;
        if (r != 0 && ((r < 0) != (na < 0)))
            q = q - 1;
        return q[31:0];
    endfunction

    function automatic out_beat_t calc_step(in_beat_t op);
        out_beat_t res;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] r;
        res.value = '0;
        res.status = ST_OK;
        case (op.func)
            FUNC_PUSH:
                if (calc_count >= DEPTH)
                    res.status = ST_FULL;
                else
                begin
                    calc_mem[calc_count] = op.push_value;
                    calc_count++;
                end
            FUNC_POP:
                if (calc_count == 0)
                    res.status = ST_EMPTY;
                else
                begin
                    res.value = calc_mem[calc_count - 1];
                    calc_count--;
                end
            FUNC_RD_TOP, FUNC_RD_BOT:
                if (op.index >= calc_count)
                    res.status = ST_RANGE;
                else if (op.func == FUNC_RD_TOP)
                    res.value = calc_mem[calc_count - 1 - op.index];
                else
                    res.value = calc_mem[op.index];
            default:
                if (calc_count < 2)
                    res.status = ST_FEW;
                else
                begin
                    a = calc_mem[calc_count - 1];
                    b = calc_mem[calc_count - 2];
                    if (op.func == FUNC_DIV && a == 0)
                    begin
                        res.status = ST_DIV0;
                        calc_count -= 2;
                    end
                    else
                    begin
                        case (op.func)
                            FUNC_ADD: r = a + b;
                            FUNC_SUB: r = b - a;
                            FUNC_MUL: r = a * b;
                            default: r = floor_quotient(b, a);
                        endcase
                        calc_mem[calc_count - 2] = r;
                        calc_count--;
                        res.value = r;
                    end
                end
        endcase
        res.depth = calc_count[6:0];
        return res;
    endfunction

    task automatic send_beat(in_beat_t op, bit known, out_beat_t typed);
        out_beat_t predicted;
        int gap;
        gap = 1;
        if (!in_quiet && $urandom_range(0, 5) == 0)
            gap = 1 + $urandom_range(1, 10);
        repeat (gap) @(posedge clk);
        in_valid <= 1'b1;
        in_data <= op;
        predicted = calc_step(op);
        if (known && predicted !== typed)
            $display("table row disagrees with predictor: %p vs %p", typed, predicted);
        result_queue.push_back(known ? typed : predicted);
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        in_valid <= 1'b0;
    endtask

    function automatic logic [31:0] random_operand();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'hffff_ffff;
            3: return 32'($urandom_range(0, 4));
            4: return 32'($signed($urandom_range(0, 20)) - 10);
            default: return $urandom;
        endcase
    endfunction

    task automatic run_op(logic [2:0] f, logic [31:0] v, logic [5:0] idx);
        in_beat_t op;
        op.func = f;
        op.push_value = v;
        op.index = idx;
        send_beat(op, 1'b0, '0);
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            cycle_count <= cycle_count + 1;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("stack_calculator_engine_unit: mismatch");
                $finish;
            end
            if (out_valid && !out_stall)
            begin
                if (result_queue.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected result beat %p", out_data);
                end
                else
                begin
                    if (out_data !== result_queue[0])
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("expected %p got %p", result_queue[0], out_data);
                    end
                    void'(result_queue.pop_front());
                end
            end
            if (out_quiet)
                out_stall <= 1'b0;
            else if (out_burst > 0)
            begin
                out_burst <= out_burst - 1;
                out_stall <= (out_burst > 1);
            end
            else if ($urandom_range(0, 7) == 0)
            begin
                out_burst <= $urandom_range(1, 10);
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    initial
    begin
        stim_row_t rows [$];
        stim_row_t row;
        in_beat_t op;
        out_beat_t typed;
        int i;
        int pick;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_stall = 1'b0;
        out_burst = 0;
        in_quiet = 1'b0;
        out_quiet = 1'b0;
        mismatch_count = 0;
        cycle_count = 0;
        calc_count = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        rows = '{
            '{FUNC_POP, 32'h0, 6'd0, 1'b1, 32'h0, ST_EMPTY, 7'd0},
            '{FUNC_RD_TOP, 32'h0, 6'd0, 1'b1, 32'h0, ST_RANGE, 7'd0},
            '{FUNC_RD_BOT, 32'h0, 6'd63, 1'b1, 32'h0, ST_RANGE, 7'd0},
            '{FUNC_ADD, 32'h0, 6'd0, 1'b1, 32'h0, ST_FEW, 7'd0},
            '{FUNC_PUSH, 32'h8000_0000, 6'd0, 1'b1, 32'h0, ST_OK, 7'd1},
            '{FUNC_DIV, 32'h0, 6'd0, 1'b1, 32'h0, ST_FEW, 7'd1},
            '{FUNC_PUSH, 32'hffff_ffff, 6'd0, 1'b1, 32'h0, ST_OK, 7'd2},
            '{FUNC_DIV, 32'h0, 6'd0, 1'b1, 32'h8000_0000, ST_OK, 7'd1},
            '{FUNC_PUSH, 32'h0, 6'd0, 1'b1, 32'h0, ST_OK, 7'd2},
            '{FUNC_DIV, 32'h0, 6'd0, 1'b1, 32'h0, ST_DIV0, 7'd0},
            '{FUNC_PUSH, 32'h7fff_ffff, 6'd0, 1'b1, 32'h0, ST_OK, 7'd1},
            '{FUNC_PUSH, 32'h1, 6'd0, 1'b1, 32'h0, ST_OK, 7'd2},
            '{FUNC_ADD, 32'h0, 6'd0, 1'b1, 32'h8000_0000, ST_OK, 7'd1},
            '{FUNC_PUSH, 32'h3, 6'd0, 1'b0, 32'h0, ST_OK, 7'd0},
            '{FUNC_SUB, 32'h0, 6'd0, 1'b0, 32'h0, ST_OK, 7'd0},
            '{FUNC_PUSH, 32'hffff_fff9, 6'd0, 1'b0, 32'h0, ST_OK, 7'd0},
            '{FUNC_MUL, 32'h0, 6'd0, 1'b0, 32'h0, ST_OK, 7'd0},
            '{FUNC_PUSH, 32'h2, 6'd0, 1'b0, 32'h0, ST_OK, 7'd0},
            '{FUNC_DIV, 32'h0, 6'd0, 1'b0, 32'h0, ST_OK, 7'd0},
            '{FUNC_PUSH, 32'hffff_fffe, 6'd0, 1'b0, 32'h0, ST_OK, 7'd0},
            '{FUNC_DIV, 32'h0, 6'd0, 1'b0, 32'h0, ST_OK, 7'd0},
            '{FUNC_RD_TOP, 32'h0, 6'd0, 1'b0, 32'h0, ST_OK, 7'd0},
            '{FUNC_RD_BOT, 32'h0, 6'd0, 1'b0, 32'h0, ST_OK, 7'd0},
            '{FUNC_POP, 32'h0, 6'd0, 1'b0, 32'h0, ST_OK, 7'd0}
        };
        foreach (rows[k])
        begin
            row = rows[k];
            op.func = row.func;
            op.push_value = row.operand;
            op.index = row.index;
            typed.value = row.value;
            typed.status = row.status;
            typed.depth = row.depth;
            send_beat(op, row.known, typed);
        end

        // fill to full, hit the full case and deep reads, then drain
        while (calc_count < DEPTH)
            run_op(FUNC_PUSH, $urandom, 6'($urandom));
        run_op(FUNC_PUSH, 32'h1234_5678, 6'd0);
        run_op(FUNC_RD_TOP, 32'h0, 6'd63);
        run_op(FUNC_RD_BOT, 32'h0, 6'd63);
        while (calc_count > 0)
            run_op(FUNC_POP, $urandom, 6'($urandom));

        while (result_queue.size() != 0)
            @(posedge clk);
        @(posedge clk);

        for (i = 0; i < RANDOM_OPS; i++)
        begin
            if (i == RANDOM_OPS - 150)
            begin
                in_quiet = 1'b1;
                out_quiet = 1'b1;
            end
            if (i == RANDOM_OPS / 2)
            begin
                while (result_queue.size() != 0)
                    @(posedge clk);
                @(posedge clk);
            end
            pick = $urandom_range(0, 99);
            op.push_value = random_operand();
            op.index = 6'($urandom);
            if (calc_count > 0 && $urandom_range(0, 1) == 1)
                op.index = 6'($urandom_range(0, calc_count));
            if (pick < 35 && calc_count < DEPTH - 2)
                op.func = FUNC_PUSH;
            else if (pick < 45)
                op.func = FUNC_POP;
            else if (pick < 60)
                op.func = ($urandom_range(0, 1) == 1) ? FUNC_RD_TOP : FUNC_RD_BOT;
            else
                op.func = 3'($urandom_range(FUNC_ADD, FUNC_DIV));
            if (calc_count < 2 && pick >= 45 && $urandom_range(0, 3) != 0)
                op.func = FUNC_PUSH;
            send_beat(op, 1'b0, '0);
        end

        while (result_queue.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (mismatch_count == 0)
            $display("stack_calculator_engine_unit: match");
        else
            $display("stack_calculator_engine_unit: mismatch");
        $finish;
    end
endmodule
